// ===== hdl/smoothed_coefficient_biquad_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the smoothed coefficient biquad unit
// Same-cycle implication and next-cycle property wrappers on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_COEFFICIENT_BIQUAD_UNIT_ASSERT_SVH
`define SMOOTHED_COEFFICIENT_BIQUAD_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SCBQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define SCBQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/scbq_pkg.sv =====
// ----------------------------------------------------------------------------
// scbq_pkg
// Shared types, codes and the sequencer program of the biquad unit.
// ----------------------------------------------------------------------------
package scbq_pkg;

	localparam int NUM_COEFFS = 5;
	localparam int IDX_W      = 3;
	localparam int STEP_W     = 4;
	localparam int GLIDE_W    = 16;
	localparam int COEFF_INT  = 4;

	// register indexes; coefficient slots share the first five codes
	typedef enum logic [IDX_W-1:0] {
		REG_FF0   = 3'd0,
		REG_FF1   = 3'd1,
		REG_FF2   = 3'd2,
		REG_FB1   = 3'd3,
		REG_FB2   = 3'd4,
		REG_GLIDE = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2,
		ACC_SUB  = 2'd3
	} acc_op_t;

	typedef enum logic [1:0] {
		BR_NEXT = 2'd0,   // fall through
		BR_IN   = 2'd1,   // wait here for an input item
		BR_OUT  = 2'd2,   // wait for a free output register, then home
		BR_HOME = 2'd3    // jump to the idle step
	} br_t;

	typedef struct packed {
		logic     mul_glide;   // 1: (target - live) * rate, 0: live * sample
		reg_idx_t mul_idx;
		logic     upd_en;      // write a glided coefficient from the product
		reg_idx_t upd_idx;
		acc_op_t  acc_op;
		br_t      br;
	} ctl_t;

	localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;

	// microprogram: one control word per step
	function automatic ctl_t prog(input logic [STEP_W-1:0] step);
		ctl_t c;
		c = '0;
		unique case (step)
			4'd0: c.br = BR_IN;
			4'd1: begin
				c.mul_glide = 1'b1;
				c.mul_idx   = REG_FF0;
			end
			4'd2: begin
				c.mul_glide = 1'b1;
				c.mul_idx   = REG_FF1;
				c.upd_en    = 1'b1;
				c.upd_idx   = REG_FF0;
			end
			4'd3: begin
				c.mul_glide = 1'b1;
				c.mul_idx   = REG_FF2;
				c.upd_en    = 1'b1;
				c.upd_idx   = REG_FF1;
			end
			4'd4: begin
				c.mul_glide = 1'b1;
				c.mul_idx   = REG_FB1;
				c.upd_en    = 1'b1;
				c.upd_idx   = REG_FF2;
			end
			4'd5: begin
				c.mul_glide = 1'b1;
				c.mul_idx   = REG_FB2;
				c.upd_en    = 1'b1;
				c.upd_idx   = REG_FB1;
			end
			4'd6: begin
				c.mul_idx = REG_FF0;
				c.upd_en  = 1'b1;
				c.upd_idx = REG_FB2;
			end
			4'd7: begin
				c.mul_idx = REG_FF1;
				c.acc_op  = ACC_LOAD;
			end
			4'd8: begin
				c.mul_idx = REG_FF2;
				c.acc_op  = ACC_ADD;
			end
			4'd9: begin
				c.mul_idx = REG_FB1;
				c.acc_op  = ACC_ADD;
			end
			4'd10: begin
				c.mul_idx = REG_FB2;
				c.acc_op  = ACC_SUB;
			end
			4'd11: c.acc_op = ACC_SUB;
			4'd12: c.br = BR_OUT;
			default: c.br = BR_HOME;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/scbq_mac.sv =====
// ----------------------------------------------------------------------------
// scbq_mac
// Shared multiplier with product register, accumulator, and the final
// round-half-up / saturate of the accumulated sum.
// ----------------------------------------------------------------------------
module scbq_mac #(
	parameter int A_WIDTH   = 25,
	parameter int B_WIDTH   = 24,
	parameter int ACC_WIDTH = 51,
	parameter int FRAC_BITS = 20,
	parameter int OUT_WIDTH = 24
) (
	input  logic                                clk,
	input  logic signed [A_WIDTH-1:0]           op_a,
	input  logic signed [B_WIDTH-1:0]           op_b,
	input  scbq_pkg::acc_op_t                   acc_op,
	output logic signed [A_WIDTH+B_WIDTH-1:0]   prod_s1,
	output logic signed [OUT_WIDTH-1:0]         y_sat
);

	localparam int PW = A_WIDTH + B_WIDTH;
	localparam int SW = ACC_WIDTH - FRAC_BITS;
	localparam logic signed [ACC_WIDTH-1:0] RoundHalf = ACC_WIDTH'(1) << (FRAC_BITS - 1);
	localparam logic signed [OUT_WIDTH-1:0] OutMax = {1'b0, {(OUT_WIDTH-1){1'b1}}};
	localparam logic signed [OUT_WIDTH-1:0] OutMin = {1'b1, {(OUT_WIDTH-1){1'b0}}};

	logic signed [ACC_WIDTH-1:0] acc_q;
	logic signed [ACC_WIDTH-1:0] prod_ext;
	logic signed [ACC_WIDTH-1:0] rounded;
	logic signed [SW-1:0]        shifted;

	assign prod_ext = ACC_WIDTH'(prod_s1);

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(op_a * op_b);
		case (acc_op)
			scbq_pkg::ACC_LOAD: acc_q <= prod_ext;
			scbq_pkg::ACC_ADD:  acc_q <= acc_q + prod_ext;
			scbq_pkg::ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:            acc_q <= acc_q;
		endcase
	end

	// floor((sum + half) / 2^frac), then clamp to the sample range
	assign rounded = acc_q + RoundHalf;
	assign shifted = rounded[ACC_WIDTH-1:FRAC_BITS];

	always_comb begin
		if (shifted[SW-1:OUT_WIDTH-1] == {(SW-OUT_WIDTH+1){shifted[SW-1]}}) begin
			y_sat = shifted[OUT_WIDTH-1:0];
		end else if (shifted[SW-1]) begin
			y_sat = OutMin;
		end else begin
			y_sat = OutMax;
		end
	end

endmodule

// ===== hdl/smoothed_coefficient_biquad_unit.sv =====
// ----------------------------------------------------------------------------
// smoothed_coefficient_biquad_unit
// Direct-form-I biquad whose five coefficients glide toward loaded targets.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / sample_in) takes one sample item;
//   output channel (out_valid / out_ready / sample_out) returns one filtered
//   item per input item, in order.
//   Targets and glide rate are loaded through cfg_we / cfg_index / cfg_data
//   while the unit is idle; indexes above the glide rate are ignored.
// Sequence:
//   each item runs one accept step, ten multiplies on one shared
//   multiplier (five glide updates, five filter taps) overlapped with the
//   accumulator, one drain step and one output step, as set by the step
//   program in scbq_pkg; the next item is taken right after the output
//   step, so only one item is computed at a time.
// Reset:
//   arst_n clears history to zero, working and target coefficients to unity
//   gain on the current input, glide rate to about 0.01, and the sequencer
//   to its idle step with no result pending.
// Stall:
//   a finished result waits in the output register while the next item is
//   accepted and computed; only the output step waits if that register is
//   still occupied.
// ----------------------------------------------------------------------------
`include "smoothed_coefficient_biquad_unit_assert.svh"

module smoothed_coefficient_biquad_unit #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEFF_WIDTH  = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration writes
	input  logic                             cfg_we,
	input  logic [scbq_pkg::IDX_W-1:0]       cfg_index,
	input  logic [COEFF_WIDTH-1:0]           cfg_data,
	// sample in
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
	// sample out
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]   sample_out
);

	localparam int CW  = COEFF_WIDTH;
	localparam int SW  = SAMPLE_WIDTH;
	localparam int GW  = scbq_pkg::GLIDE_W;
	localparam int CF  = CW - scbq_pkg::COEFF_INT;
	localparam int AW  = CW + 1;                       // target - live fits here
	localparam int BW  = (SW > GW + 1) ? SW : GW + 1;  // sample or unsigned rate
	localparam int PW  = AW + BW;
	localparam int STW = PW - GW;                      // glide step width
	localparam int UW  = STW + 1;                      // live + step
	localparam int ACW = CW + SW + 3;                  // five exact products

	localparam logic signed [CW-1:0] CoeffOne  = CW'(1) << CF;
	localparam logic signed [PW-1:0] GlideHalf = PW'(1) << (GW - 1);
	localparam logic signed [CW-1:0] CoeffMax  = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CoeffMin  = {1'b1, {(CW-1){1'b0}}};
	localparam logic [GW-1:0]        GlideReset = 16'd655;

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	logic signed [CW-1:0] target_q [scbq_pkg::NUM_COEFFS];
	logic signed [CW-1:0] live_q   [scbq_pkg::NUM_COEFFS];
	logic [GW-1:0]        glide_q;
	logic signed [SW-1:0] x0_q, x1_q, x2_q, y1_q, y2_q;
	logic signed [CW-1:0] hold_q;       // live value paired with a glide product
	logic [scbq_pkg::STEP_W-1:0] step_q;
	logic                 out_valid_q;
	logic signed [SW-1:0] sample_out_q;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	scbq_pkg::ctl_t ctl;
	logic in_fire, out_free, fin_fire;
	logic [scbq_pkg::STEP_W-1:0] step_next;

	assign ctl      = scbq_pkg::prog(step_q);
	assign in_ready = (ctl.br == scbq_pkg::BR_IN);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign fin_fire = (ctl.br == scbq_pkg::BR_OUT) && out_free;

	always_comb begin
		unique case (ctl.br)
			scbq_pkg::BR_NEXT: step_next = step_q + scbq_pkg::STEP_W'(1);
			scbq_pkg::BR_IN:   step_next = in_fire ? step_q + scbq_pkg::STEP_W'(1) : step_q;
			scbq_pkg::BR_OUT:  step_next = fin_fire ? scbq_pkg::STEP_IDLE : step_q;
			default:           step_next = scbq_pkg::STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= scbq_pkg::STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q[0] <= CoeffOne;
			target_q[1] <= '0;
			target_q[2] <= '0;
			target_q[3] <= '0;
			target_q[4] <= '0;
			glide_q     <= GlideReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scbq_pkg::REG_FF0:   target_q[0] <= cfg_data;
				scbq_pkg::REG_FF1:   target_q[1] <= cfg_data;
				scbq_pkg::REG_FF2:   target_q[2] <= cfg_data;
				scbq_pkg::REG_FB1:   target_q[3] <= cfg_data;
				scbq_pkg::REG_FB2:   target_q[4] <= cfg_data;
				scbq_pkg::REG_GLIDE: glide_q     <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Operand select
	// ------------------------------------------------------------------
	logic signed [CW-1:0] live_sel, tgt_sel;
	logic signed [SW-1:0] hist_sel;
	logic signed [AW-1:0] op_a;
	logic signed [BW-1:0] op_b;

	always_comb begin
		live_sel = '0;
		tgt_sel  = '0;
		hist_sel = '0;
		unique case (ctl.mul_idx)
			scbq_pkg::REG_FF0: begin
				live_sel = live_q[0];
				tgt_sel  = target_q[0];
				hist_sel = x0_q;
			end
			scbq_pkg::REG_FF1: begin
				live_sel = live_q[1];
				tgt_sel  = target_q[1];
				hist_sel = x1_q;
			end
			scbq_pkg::REG_FF2: begin
				live_sel = live_q[2];
				tgt_sel  = target_q[2];
				hist_sel = x2_q;
			end
			scbq_pkg::REG_FB1: begin
				live_sel = live_q[3];
				tgt_sel  = target_q[3];
				hist_sel = y1_q;
			end
			scbq_pkg::REG_FB2: begin
				live_sel = live_q[4];
				tgt_sel  = target_q[4];
				hist_sel = y2_q;
			end
			default: ;
		endcase
		if (ctl.mul_glide) begin
			op_a = AW'(tgt_sel) - AW'(live_sel);
			op_b = BW'({1'b0, glide_q});
		end else begin
			op_a = AW'(live_sel);
			op_b = BW'(hist_sel);
		end
	end

	// ------------------------------------------------------------------
	// Multiply / accumulate
	// ------------------------------------------------------------------
	logic signed [PW-1:0] prod_s1;
	logic signed [SW-1:0] y_sat;

	scbq_mac #(
		.A_WIDTH   (AW),
		.B_WIDTH   (BW),
		.ACC_WIDTH (ACW),
		.FRAC_BITS (CF),
		.OUT_WIDTH (SW)
	) u_mac (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.acc_op  (ctl.acc_op),
		.prod_s1 (prod_s1),
		.y_sat   (y_sat)
	);

	// ------------------------------------------------------------------
	// Coefficient glide: live += floor((diff * rate + half) / 2^16)
	// ------------------------------------------------------------------
	logic signed [PW-1:0]  glide_rnd;
	logic signed [STW-1:0] glide_step;
	logic signed [UW-1:0]  glide_sum;
	logic signed [CW-1:0]  glide_new;

	assign glide_rnd  = prod_s1 + GlideHalf;
	assign glide_step = glide_rnd[PW-1:GW];
	assign glide_sum  = UW'(hold_q) + UW'(glide_step);

	always_comb begin
		if (glide_sum[UW-1:CW-1] == {(UW-CW+1){glide_sum[UW-1]}}) begin
			glide_new = glide_sum[CW-1:0];
		end else if (glide_sum[UW-1]) begin
			glide_new = CoeffMin;
		end else begin
			glide_new = CoeffMax;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_glide) begin
			hold_q <= live_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q[0] <= CoeffOne;
			live_q[1] <= '0;
			live_q[2] <= '0;
			live_q[3] <= '0;
			live_q[4] <= '0;
		end else if (ctl.upd_en) begin
			unique case (ctl.upd_idx)
				scbq_pkg::REG_FF0: live_q[0] <= glide_new;
				scbq_pkg::REG_FF1: live_q[1] <= glide_new;
				scbq_pkg::REG_FF2: live_q[2] <= glide_new;
				scbq_pkg::REG_FB1: live_q[3] <= glide_new;
				scbq_pkg::REG_FB2: live_q[4] <= glide_new;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// History and output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q <= '0;
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else begin
			if (in_fire) begin
				x0_q <= sample_in;
			end
			if (fin_fire) begin
				x1_q <= x0_q;
				x2_q <= x1_q;
				y1_q <= y_sat;
				y2_q <= y1_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			sample_out_q <= y_sat;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// an accepted item keeps the input closed while it is computed
	`SCBQ_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready, "input open right after accept")
	// a blocked output step neither moves nor touches the history
	`SCBQ_ASSERT_NEXT(a_out_step_holds, (ctl.br == scbq_pkg::BR_OUT) && !out_free, (step_q == scbq_pkg::STEP_LAST) && $stable(y1_q), "output step moved while blocked")
	// the delivered sample is the one fed back as the newest output
	`SCBQ_ASSERT_NEXT(a_out_matches_hist, fin_fire, out_valid && (sample_out == y1_q), "output and feedback history differ")

endmodule

// ===== tb/scbq_biquad_checker.sv =====
// ----------------------------------------------------------------------------
// scbq_biquad_checker
// Tracks register writes and accepted samples, predicts each filtered item
// with gliding coefficients, and compares the output channel against it.
// ----------------------------------------------------------------------------
module scbq_biquad_checker #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEFF_WIDTH  = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [scbq_pkg::IDX_W-1:0]     cfg_index,
	input  logic [COEFF_WIDTH-1:0]         cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output int                             filtered_owed,
	output int                             mismatches
);

	localparam int COEFF_FRAC = COEFF_WIDTH - scbq_pkg::COEFF_INT;

	longint target_coef [scbq_pkg::NUM_COEFFS];
	longint glided_coef [scbq_pkg::NUM_COEFFS];
	longint glide_q16;
	longint x_hist [2];
	longint y_hist [2];
	logic signed [SAMPLE_WIDTH-1:0] filtered_due [$];
	int bad_count;

	function automatic longint clip(input longint v, input int w);
		longint hi;
		hi = (longint'(1) << (w - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		longint x0;
		longint acc;
		longint y;
		logic signed [SAMPLE_WIDTH-1:0] want;
		if (!arst_n) begin
			for (int i = 0; i < scbq_pkg::NUM_COEFFS; i++) begin
				target_coef[i] = 0;
				glided_coef[i] = 0;
			end
			target_coef[scbq_pkg::REG_FF0] = longint'(1) << COEFF_FRAC;
			glided_coef[scbq_pkg::REG_FF0] = longint'(1) << COEFF_FRAC;
			glide_q16 = 655;
			x_hist[0] = 0;
			x_hist[1] = 0;
			y_hist[0] = 0;
			y_hist[1] = 0;
			filtered_due.delete();
			bad_count = 0;
			filtered_owed <= 0;
			mismatches <= 0;
		end else begin
			// writes to indexes past the glide rate fall through untouched
			if (cfg_we) begin
				if (cfg_index <= scbq_pkg::REG_FB2)
					target_coef[cfg_index] = longint'($signed(cfg_data));
				else if (cfg_index == scbq_pkg::REG_GLIDE)
					glide_q16 = longint'(cfg_data[scbq_pkg::GLIDE_W-1:0]);
			end

			if (in_valid && in_ready) begin
				// glide first, round half up, stay in coefficient range
				for (int i = 0; i < scbq_pkg::NUM_COEFFS; i++)
					glided_coef[i] = clip(glided_coef[i] +
						(((target_coef[i] - glided_coef[i]) * glide_q16 + 32768) >>> 16),
						COEFF_WIDTH);
				x0 = longint'(sample_in);
				acc = glided_coef[scbq_pkg::REG_FF0] * x0
					+ glided_coef[scbq_pkg::REG_FF1] * x_hist[0]
					+ glided_coef[scbq_pkg::REG_FF2] * x_hist[1]
					- glided_coef[scbq_pkg::REG_FB1] * y_hist[0]
					- glided_coef[scbq_pkg::REG_FB2] * y_hist[1];
				y = clip((acc + (longint'(1) << (COEFF_FRAC - 1))) >>> COEFF_FRAC,
					SAMPLE_WIDTH);
				x_hist[1] = x_hist[0];
				x_hist[0] = x0;
				y_hist[1] = y_hist[0];
				y_hist[0] = y;
				filtered_due.push_back(y[SAMPLE_WIDTH-1:0]);
			end

			if (out_valid && out_ready) begin
				if (filtered_due.size() == 0) begin
					$error("sample_out: item with none expected, actual %0d", sample_out);
					bad_count++;
				end else begin
					want = filtered_due.pop_front();
					if (sample_out !== want) begin
						$error("sample_out mismatch: expected %0d, actual %0d",
							want, sample_out);
						bad_count++;
					end
				end
			end

			filtered_owed <= filtered_due.size();
			mismatches <= bad_count;
		end
	end

endmodule

// ===== tb/tb_smoothed_coefficient_biquad_unit.sv =====
// ----------------------------------------------------------------------------
// tb_smoothed_coefficient_biquad_unit
// Drives samples, target coefficients and glide rates into the biquad unit
// with random gaps and output stalls; a checker beside the unit predicts
// every filtered item and counts mismatches for the verdict here.
// ----------------------------------------------------------------------------
module tb_smoothed_coefficient_biquad_unit;

	localparam int SAMPLE_W     = 24;
	localparam int COEFF_W      = 24;
	localparam int IDX_W        = scbq_pkg::IDX_W;
	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;   // long output stall, fills the unit
	localparam int DRAIN_CYCLES = 40;    // extra idle time after the final drain
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 128;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	localparam int COEF_MAX    = 8388607;
	localparam int COEF_MIN    = -8388608;
	localparam int COEF_UNITY  = 1 << 20;     // 1.0 in Q4.20
	localparam int COEF_HALF   = 1 << 19;     // 0.5, makes rounding ties
	localparam int GLIDE_MAX   = 65535;
	localparam int GLIDE_RESET = 655;
	localparam int GLIDE_FROZEN = 0;

	// register indexes with no register behind them
	localparam logic [IDX_W-1:0] IDX_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_B = 3'd7;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [IDX_W-1:0]           cfg_index = '0;
	logic [COEFF_W-1:0]         cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;

	int filtered_owed;
	int mismatches;

	bit gaps_on   = 1'b1;   // random idling on both channels
	bit hold_req  = 1'b0;   // ask the receiver for a long stall
	int hold_left = 0;
	int cycles    = 0;

	always #HALF_PERIOD clk = ~clk;

	smoothed_coefficient_biquad_unit #(
		.SAMPLE_WIDTH (SAMPLE_W),
		.COEFF_WIDTH  (COEFF_W)
	) u_dut (
		.clk, .arst_n,
		.cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .sample_in,
		.out_valid, .out_ready, .sample_out
	);

	scbq_biquad_checker #(
		.SAMPLE_WIDTH (SAMPLE_W),
		.COEFF_WIDTH  (COEFF_W)
	) u_checker (
		.clk, .arst_n,
		.cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .sample_in,
		.out_valid, .out_ready, .sample_out,
		.filtered_owed, .mismatches
	);

	// Offer one sample item. in_valid stays high from item to item when no
	// gap is drawn, so it is never lowered and raised in the same step.
	task automatic offer(input logic signed [SAMPLE_W-1:0] s);
		while (gaps_on && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every filtered item has come back. The
	// first edge lets the checker count the item accepted just now.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (filtered_owed != 0)
			@(posedge clk);
	endtask

	// cfg_we is left high; the caller lowers it after the last write
	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [COEFF_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	task automatic load_targets(input int ff0, input int ff1, input int ff2,
			input int fb1, input int fb2, input int rate);
		cfg_write(scbq_pkg::REG_FF0, COEFF_W'(ff0));
		cfg_write(scbq_pkg::REG_FF1, COEFF_W'(ff1));
		cfg_write(scbq_pkg::REG_FF2, COEFF_W'(ff2));
		cfg_write(scbq_pkg::REG_FB1, COEFF_W'(fb1));
		cfg_write(scbq_pkg::REG_FB2, COEFF_W'(fb2));
		cfg_write(scbq_pkg::REG_GLIDE, COEFF_W'(rate));
		cfg_we <= 1'b0;
	endtask

	// mostly full-range noise, some quiet signal, some rail values
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 15)
			return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
		if (roll < 40)
			return SAMPLE_W'($urandom_range(8191) - 4096);
		return SAMPLE_W'($urandom());
	endfunction

	// target per phase style: rails, raw noise, or a sane filter range
	function automatic int pick_target(input int phase, input int span);
		case (phase)
			3: return COEF_MAX;
			4: return COEF_MIN;
			5: return $urandom();
			default: return $urandom_range(2 * span) - span;
		endcase
	endfunction

	function automatic int pick_rate(input int phase);
		case (phase)
			0: return GLIDE_RESET;
			1: return GLIDE_FROZEN;
			2: return GLIDE_MAX;
			default: return $urandom_range(GLIDE_MAX);
		endcase
	endfunction

	// Receiver: random stalls, plus a long hold-off counted here on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !gaps_on || $urandom_range(99) >= 29;
			end
		end
	end

	// Watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset targets: unity on the current input, so items pass straight
		// through. Rails, zero, +/-1 and alternating bit patterns.
		offer('0);
		offer(SAMPLE_MAX);
		offer(SAMPLE_MIN);
		offer(SAMPLE_W'(1));
		offer(SAMPLE_W'(-1));
		offer(24'h555555);
		offer(24'hAAAAAA);

		// Writes to unmapped indexes must be dropped. Then full-scale targets
		// with the fastest glide, driving the output into both rails.
		drain();
		cfg_write(IDX_SPARE_A, COEFF_W'($urandom()));
		cfg_write(IDX_SPARE_B, COEFF_W'($urandom()));
		load_targets(COEF_MAX, COEF_MIN, 0, 0, 0, GLIDE_MAX);
		offer(SAMPLE_MAX);
		offer(SAMPLE_MIN);
		offer(SAMPLE_MAX);
		offer('0);
		offer(SAMPLE_W'(1));
		offer(SAMPLE_W'(-1));

		// Zero glide rate: new targets, coefficients must stay frozen.
		drain();
		load_targets(0, COEF_UNITY, -COEF_UNITY, COEF_UNITY, -COEF_UNITY, GLIDE_FROZEN);
		repeat (3) offer(pick_sample());

		// Gain of one half: after two settling zeros, odd inputs land exactly
		// on half a step, so +1 rounds up to 1 and -1 rounds up to 0.
		drain();
		load_targets(COEF_HALF, 0, 0, 0, 0, GLIDE_MAX);
		offer('0);
		offer('0);
		offer(SAMPLE_W'(1));
		offer(SAMPLE_W'(-1));
		offer(SAMPLE_W'(3));
		offer(SAMPLE_W'(-3));

		// Random phases, each with its own register set. Phase 6 runs without
		// any idling; phases 3 and 7 take a long output stall while items keep
		// coming, and phase 7 also pauses the sender until all items return.
		for (int p = 0; p < PHASES; p++) begin
			drain();
			cfg_write($urandom_range(1) ? IDX_SPARE_A : IDX_SPARE_B, COEFF_W'($urandom()));
			load_targets(pick_target(p, 1 << 20), pick_target(p, 1 << 20),
				pick_target(p, 1 << 20), pick_target(p, 1 << 21),
				pick_target(p, 1 << 20), pick_rate(p));
			gaps_on = (p != 6);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ((p == 3 || p == 7) && n == 40)
					hold_req = 1'b1;
				if (p == 7 && n == 90)
					drain();
				offer(pick_sample());
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && filtered_owed == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
